>>> design/dspc_pkg.sv
// Shared constants, types and elaboration-time tables for the drive stick power curve.
package dspc_pkg;

  localparam int OUT_FRAC_BITS = 12;
  localparam int LOG_STAGES    = 16;
  localparam int EXP_STAGES    = 16;
  // stage 0 input, 1 lookup, 2..17 log/delay, 18 multiply, 19 exponent split,
  // 20..35 exp2 products, 36 output
  localparam int DEPTH         = 37;

  localparam logic [2:0] REG_DRIVE_MODE   = 3'd0;
  localparam logic [2:0] REG_CURVE_GAIN   = 3'd1;
  localparam logic [2:0] REG_MIN_VOLTS    = 3'd2;
  localparam logic [2:0] REG_FULL_STICK   = 3'd3;
  localparam logic [2:0] REG_DEADBAND_PCT = 3'd4;

  localparam logic [16:0] SAT_VOLTS = 17'(12 << OUT_FRAC_BITS);

  typedef logic [19:0] log_tab_t [256];
  typedef logic [30:0] fac_tab_t [16];

  // log2 in Q16 by repeated squaring of the normalized mantissa
  function automatic logic [19:0] log2_q16(input logic [15:0] n);
    logic [63:0] m;
    logic [15:0] r;
    int e;
    e = 0;
    while (e < 16 && ((n >> (e + 1)) != 16'd0)) e++;
    m = 64'(n) << (30 - e);
    r = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      r = {r[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r[0] = 1'b1;
      end
    end
    return {4'(e), r};
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = '0;
    v = x;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = log2_q16(16'(i + 1));
    return t;
  endfunction

  // 2^(2^-k) in Q30, k = 1..16
  function automatic fac_tab_t build_fac_tab();
    fac_tab_t t;
    logic [63:0] f;
    f = isqrt64(64'd1 << 61);
    t[0] = 31'(f);
    for (int k = 1; k < 16; k++) begin
      f = isqrt64(f << 30);
      t[k] = 31'(f);
    end
    return t;
  endfunction

  localparam logic [19:0] LOG2_TWELVE = log2_q16(16'd12);
  localparam logic [19:0] LOG2_FULL   = log2_q16(16'd3072);

  typedef struct packed {
    logic [3:0]  e;
    logic [30:0] m;
    logic [15:0] r;
  } log_stage_t;

  typedef struct packed {
    logic               neg;
    logic               zero;
    logic signed [21:0] diff;
  } lane_head_t;

  typedef struct packed {
    logic        neg;
    logic        zero;
    logic        sat;
    logic        tiny;
    logic [5:0]  sh;
    logic [15:0] fr;
    logic [30:0] acc;
  } exp_stage_t;

endpackage

>>> design/dspc_log2.sv
// Pipelined log2 of the full-stick point, shared by both lanes.
module dspc_log2 (
  input  logic        clk,
  input  logic        en,
  input  logic [14:0] fs,
  output logic [19:0] log_fs
);
  import dspc_pkg::*;

  log_stage_t st [LOG_STAGES+1];
  logic [3:0] e0;

  always_comb begin
    e0 = '0;
    for (int i = 1; i < 15; i++) begin
      if (fs[i]) e0 = 4'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].e <= e0;
      st[0].m <= 31'({16'd0, fs} << (5'd30 - 5'(e0)));
      st[0].r <= '0;
    end
  end

  for (genvar k = 0; k < LOG_STAGES; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] msq;
    assign sq  = st[k].m * st[k].m;
    assign msq = sq[61:30];
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].e <= st[k].e;
        st[k+1].m <= msq[31] ? msq[31:1] : msq[30:0];
        st[k+1].r <= {st[k].r[14:0], msq[31]};
      end
    end
  end

  assign log_fs = {st[LOG_STAGES].e, st[LOG_STAGES].r};
endmodule

>>> design/dspc_lane.sv
// One side of the curve: deadband, log lookup, exponent, exp2 product chain, min-volts offset and saturation.
module dspc_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [9:0]  v,
  input  logic signed [35:0] fs_term,
  input  logic [11:0]        curve_gain,
  input  logic [11:0]        min_volts,
  input  logic [14:0]        deadband_pct,
  output logic [16:0]        volts
);
  import dspc_pkg::*;

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam fac_tab_t FAC     = build_fac_tab();

  logic [9:0]  mag;
  logic [23:0] mag_scaled;
  logic [23:0] db_scaled;
  lane_head_t  head;
  lane_head_t  dly [LOG_STAGES];
  logic signed [35:0] gterm;
  logic               m_neg;
  logic               m_zero;
  logic signed [36:0] l24;
  logic signed [12:0] ip;
  logic signed [13:0] sh_full;
  exp_stage_t  ex [EXP_STAGES+1];
  logic [47:0] rnd;
  logic [16:0] y;
  logic [17:0] total;
  logic [16:0] mag_out;

  assign mag        = v[9] ? 10'(-v) : 10'(v);
  assign mag_scaled = 24'(mag) * 24'd25600;
  assign db_scaled  = 24'(deadband_pct) * 24'd144;

  always_ff @(posedge clk) begin
    if (en) begin
      head.neg  <= v[9];
      head.zero <= (mag == 10'd0) || (mag_scaled < db_scaled);
      head.diff <= $signed({2'b0, LOG_TAB[8'(mag - 10'd1)]})
                 - $signed({2'b0, LOG2_TWELVE});
      dly[0]    <= head;
    end
  end

  for (genvar i = 1; i < LOG_STAGES; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) dly[i] <= dly[i-1];
    end
  end

  // gain times the stick log, aligned with the shared full-stick term
  always_ff @(posedge clk) begin
    if (en) begin
      gterm  <= 36'($signed({1'b0, curve_gain})) * 36'(dly[LOG_STAGES-1].diff);
      m_neg  <= dly[LOG_STAGES-1].neg;
      m_zero <= dly[LOG_STAGES-1].zero;
    end
  end

  assign l24     = 37'(gterm) - 37'(fs_term);
  assign ip      = 13'(l24 >>> 24);
  assign sh_full = 14'(30 - OUT_FRAC_BITS) - 14'(ip);

  always_ff @(posedge clk) begin
    if (en) begin
      ex[0].neg  <= m_neg;
      ex[0].zero <= m_zero;
      ex[0].sat  <= ip >= 13'sd4;
      ex[0].tiny <= sh_full >= 14'sd40;
      ex[0].sh   <= sh_full[5:0];
      ex[0].fr   <= l24[23:8];
      ex[0].acc  <= 31'd1 << 30;
    end
  end

  for (genvar k = 0; k < EXP_STAGES; k++) begin : g_exp
    logic [61:0] prod;
    exp_stage_t  nxt;
    assign prod = ex[k].acc * FAC[k];
    always_comb begin
      nxt = ex[k];
      if (ex[k].fr[15-k]) nxt.acc = prod[60:30];
    end
    always_ff @(posedge clk) begin
      if (en) ex[k+1] <= nxt;
    end
  end

  assign rnd   = (48'(ex[EXP_STAGES].acc) + (48'd1 << (ex[EXP_STAGES].sh - 6'd1)))
                 >> ex[EXP_STAGES].sh;
  assign y     = ex[EXP_STAGES].tiny ? 17'd0 : rnd[16:0];
  assign total = 18'(y) + (18'(min_volts) << (OUT_FRAC_BITS - 8));

  always_comb begin
    if (ex[EXP_STAGES].sat || total > 18'(SAT_VOLTS)) mag_out = SAT_VOLTS;
    else mag_out = total[16:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ex[EXP_STAGES].zero) volts <= '0;
      else if (ex[EXP_STAGES].neg) volts <= 17'd0 - mag_out;
      else volts <= mag_out;
    end
  end
endmodule

>>> design/drive_stick_power_curve_core.sv
// Top level: config registers, input mix, shared log unit, two lanes, output merge.
//
//  channel | dir | handshake             | payload
//  s_      | in  | s_tvalid / s_tready   | s_tdata[15:0] first_axis, second_axis
//  m_      | out | m_tvalid / m_tready   | m_tdata[39:0] left_volts, right_volts
//  cfg_    | in  | cfg_we                | cfg_addr register index, cfg_wdata value
//
// The pipeline accepts one word per cycle, sustained while m_tready stays high;
// it runs the shared 16-stage log2 squaring chain and, in each lane, a 16-stage
// exp2 product chain, all in lockstep. Reset clears the config registers to
// their defaults and empties the pipeline. When the result word is held by a
// low m_tready the whole pipeline holds and s_tready drops.
module drive_stick_power_curve_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // [7:0] first_axis, [15:8] second_axis
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [16:0] left_volts, [33:17] right_volts, zero fill
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);
  import dspc_pkg::*;

  logic        drive_mode;
  logic [11:0] curve_gain;
  logic [11:0] min_volts;
  logic [14:0] full_stick;
  logic [14:0] deadband_pct;

  logic [DEPTH-1:0] vld;
  logic             en;

  logic signed [7:0]  a;
  logic signed [7:0]  b;
  logic signed [9:0]  v_left;
  logic signed [9:0]  v_right;
  logic [14:0]        fs_eff;
  logic [19:0]        log_fs;
  logic signed [35:0] fs_term;
  logic [16:0]        left_volts;
  logic [16:0]        right_volts;

  // config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode   <= 1'b1;
      curve_gain   <= 12'd768;
      min_volts    <= 12'd256;
      full_stick   <= 15'd3072;
      deadband_pct <= 15'd768;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DRIVE_MODE:   drive_mode   <= cfg_wdata[0];
        REG_CURVE_GAIN:   curve_gain   <= cfg_wdata[11:0];
        REG_MIN_VOLTS:    min_volts    <= cfg_wdata[11:0];
        REG_FULL_STICK:   full_stick   <= cfg_wdata;
        REG_DEADBAND_PCT: deadband_pct <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance the whole pipeline unless the result word is stuck
  assign en       = !vld[DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // mix the axes: tank passes through, arcade takes sum and difference
  assign a = s_tdata[7:0];
  assign b = s_tdata[15:8];

  always_ff @(posedge clk) begin
    if (en) begin
      if (drive_mode) begin
        v_left  <= 10'(a) + 10'(b);
        v_right <= 10'(a) - 10'(b);
      end else begin
        v_left  <= 10'(a);
        v_right <= 10'(b);
      end
      fs_eff <= (full_stick == 15'd0) ? 15'd1 : full_stick;
    end
  end

  dspc_log2 u_log2 (
    .clk    (clk),
    .en     (en),
    .fs     (fs_eff),
    .log_fs (log_fs)
  );

  // shared full-stick term (g - 1) * log2(f / 3072), same for both sides
  always_ff @(posedge clk) begin
    if (en) begin
      fs_term <= 36'($signed({1'b0, curve_gain}) - 14'sd256)
                 * 36'($signed({2'b0, log_fs}) - $signed({2'b0, LOG2_FULL}));
    end
  end

  dspc_lane u_left (
    .clk          (clk),
    .en           (en),
    .v            (v_left),
    .fs_term      (fs_term),
    .curve_gain   (curve_gain),
    .min_volts    (min_volts),
    .deadband_pct (deadband_pct),
    .volts        (left_volts)
  );

  dspc_lane u_right (
    .clk          (clk),
    .en           (en),
    .v            (v_right),
    .fs_term      (fs_term),
    .curve_gain   (curve_gain),
    .min_volts    (min_volts),
    .deadband_pct (deadband_pct),
    .volts        (right_volts)
  );

  // merge both sides into one result word
  assign m_tdata = {6'd0, right_volts, left_volts};

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted word did not enter the pipeline");

  a_stall_only_on_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a held result");

  a_left_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(left_volts) <= 17'sd49152 && $signed(left_volts) >= -17'sd49152)
    else $error("left drive beyond saturation");

  a_right_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(right_volts) <= 17'sd49152 && $signed(right_volts) >= -17'sd49152)
    else $error("right drive beyond saturation");

endmodule
